[src/pixel_tone_and_palette_match_assert.svh]
// Assertion macros shared by the palette match block.
`ifndef PIXEL_TONE_AND_PALETTE_MATCH_ASSERT_SVH
`define PIXEL_TONE_AND_PALETTE_MATCH_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PTPM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptpm: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PTPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptpm: next-cycle check failed");

`endif

[src/ptpm_pkg.sv]
// Types and constants for the pixel tone and palette match block.
package ptpm_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned TONE_W  = 3;
   localparam int unsigned INDEX_W = 6;

   localparam logic [CHAN_W-1:0] TOL_RESET     = 8'd20;
   localparam logic [CHAN_W-1:0] PURE_MIN      = 8'd128;
   localparam logic [CHAN_W-1:0] PURE_MAX      = 8'd200;
   localparam logic [CHAN_W-1:0] BROWN_MAJ_LO  = 8'd70;
   localparam logic [CHAN_W-1:0] BROWN_MAJ_HI  = 8'd150;
   localparam logic [CHAN_W-1:0] BROWN_MIN_LO  = 8'd50;
   localparam logic [CHAN_W-1:0] BROWN_MIN_HI  = 8'd100;
   localparam logic [CHAN_W-1:0] BROWN_BLUE_HI = 8'd75;

   typedef enum logic [OP_W-1:0] {
      OP_QUERY  = 2'd0,
      OP_APPEND = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [TONE_W-1:0] {
      TONE_RED         = 3'd0,
      TONE_GREEN       = 3'd1,
      TONE_RED_BROWN   = 3'd2,
      TONE_GREEN_BROWN = 3'd3,
      TONE_OTHER       = 3'd4
   } tone_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_SCAN    = 2'd1,
      ST_DELIVER = 2'd2
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic append;
      logic clear;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic exhausted;
      logic rsp_free;
   } status_type;

endpackage

[src/ptpm_ifs.sv]
// Request and response channel interfaces for the palette match block.
interface ptpm_req_if;
   import ptpm_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, operation, red, green, blue, input ready);
   modport sink   (input valid, operation, red, green, blue, output ready);
endinterface

interface ptpm_rsp_if;
   import ptpm_pkg::*;

   logic               valid;
   logic               ready;
   logic [TONE_W-1:0]  tone;
   logic               match_found;
   logic [INDEX_W-1:0] match_index;

   modport source (output valid, tone, match_found, match_index, input ready);
   modport sink   (input valid, tone, match_found, match_index, output ready);
endinterface

[src/ptpm_ctrl.sv]
// Sequencer for the palette match block: decode, scan control, result hand-off.
module ptpm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ptpm_pkg::OP_W-1:0]     req_operation,
   output logic                          req_ready,
   input  ptpm_pkg::status_type          status,
   output ptpm_pkg::cmd_type             cmd
);
   import ptpm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_operation)
                  OP_QUERY: begin
                     // drop a query when nothing is stored
                     if (!status.empty) begin
                        cmd.start = 1'b1;
                        state_in  = ST_SCAN;
                     end
                  end
                  OP_APPEND: begin
                     cmd.append = 1'b1;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                     cmd = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.exhausted) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (status.rsp_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/ptpm_datapath.sv]
// Palette store, scan comparator, tone classifier and result register.
module ptpm_datapath #(
   parameter int unsigned PALETTE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ptpm_pkg::cmd_type               cmd,
   output ptpm_pkg::status_type            status,
   input  logic [ptpm_pkg::CHAN_W-1:0]     req_red,
   input  logic [ptpm_pkg::CHAN_W-1:0]     req_green,
   input  logic [ptpm_pkg::CHAN_W-1:0]     req_blue,
   input  logic                            csr_write_enable,
   input  logic [ptpm_pkg::CHAN_W-1:0]     csr_write_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [ptpm_pkg::TONE_W-1:0]     rsp_tone,
   output logic                            rsp_match_found,
   output logic [ptpm_pkg::INDEX_W-1:0]    rsp_match_index
);
   import ptpm_pkg::*;

   localparam int unsigned CW      = $clog2(PALETTE_DEPTH + 1);
   localparam int unsigned AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int unsigned ENTRY_W = 3 * CHAN_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(PALETTE_DEPTH);

   function automatic logic near(input logic [CHAN_W-1:0] a,
                                 input logic [CHAN_W-1:0] b,
                                 input logic [CHAN_W-1:0] tol);
      logic [CHAN_W-1:0] diff;
      diff = (a >= b) ? (a - b) : (b - a);
      return diff <= tol;
   endfunction

   function automatic tone_type classify(input logic [CHAN_W-1:0] r,
                                         input logic [CHAN_W-1:0] g,
                                         input logic [CHAN_W-1:0] b);
      tone_type t;
      if (r >= PURE_MIN && g <= PURE_MAX && b <= PURE_MAX && r > g && r > b) begin
         t = TONE_RED;
      end else if (r <= PURE_MAX && g >= PURE_MIN && b <= PURE_MAX && g > r && g > b) begin
         t = TONE_GREEN;
      end else if (r >= BROWN_MAJ_LO && r <= BROWN_MAJ_HI && g >= BROWN_MIN_LO
                   && g <= BROWN_MIN_HI && b <= BROWN_BLUE_HI && r > g && g > b) begin
         t = TONE_RED_BROWN;
      end else if (g >= BROWN_MAJ_LO && g <= BROWN_MAJ_HI && r >= BROWN_MIN_LO
                   && r <= BROWN_MIN_HI && b <= BROWN_BLUE_HI && g > r && r > b) begin
         t = TONE_GREEN_BROWN;
      end else begin
         t = TONE_OTHER;
      end
      return t;
   endfunction

   logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

   logic [CW-1:0]      count_ff,     count_in;
   logic [CHAN_W-1:0]  tol_ff,       tol_in;
   logic [CHAN_W-1:0]  pix_r_ff,     pix_r_in;
   logic [CHAN_W-1:0]  pix_g_ff,     pix_g_in;
   logic [CHAN_W-1:0]  pix_b_ff,     pix_b_in;
   logic [CW-1:0]      scan_addr_ff, scan_addr_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]      cmp_idx_ff,   cmp_idx_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               found_ff,     found_in;
   logic [AW-1:0]      idx_ff,       idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TONE_W-1:0]  tone_ff,      tone_in;
   logic               mfound_ff,    mfound_in;
   logic [INDEX_W-1:0] mindex_ff,    mindex_in;

   logic full;
   logic issue;
   logic hit;

   assign full  = (count_ff == FULL_COUNT);
   assign issue = cmd.scan && (scan_addr_ff < count_ff);
   assign hit   = cmp_valid_ff
                  && near(pix_r_ff, rd_data_ff[3*CHAN_W-1:2*CHAN_W], tol_ff)
                  && near(pix_g_ff, rd_data_ff[2*CHAN_W-1:CHAN_W], tol_ff)
                  && near(pix_b_ff, rd_data_ff[CHAN_W-1:0], tol_ff);

   // memory: one write port for appends, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         mem[count_ff[AW-1:0]] <= {req_red, req_green, req_blue};
      end
      if (issue) begin
         rd_data_ff <= mem[scan_addr_ff[AW-1:0]];
      end
   end

   always_comb begin
      count_in     = count_ff;
      tol_in       = tol_ff;
      pix_r_in     = pix_r_ff;
      pix_g_in     = pix_g_ff;
      pix_b_in     = pix_b_ff;
      scan_addr_in = scan_addr_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      tone_in      = tone_ff;
      mfound_in    = mfound_ff;
      mindex_in    = mindex_ff;

      if (csr_write_enable) begin
         tol_in = csr_write_data;
      end
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && !full) begin
         count_in = count_ff + 1'b1;
      end

      if (cmd.start) begin
         pix_r_in     = req_red;
         pix_g_in     = req_green;
         pix_b_in     = req_blue;
         scan_addr_in = '0;
         cmp_valid_in = 1'b0;
         found_in     = 1'b0;
         idx_in       = '0;
      end else if (cmd.scan) begin
         cmp_valid_in = issue;
         if (issue) begin
            cmp_idx_in   = scan_addr_ff[AW-1:0];
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         if (hit) begin
            found_in = 1'b1;
            idx_in   = cmp_idx_ff;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
         tone_in      = classify(pix_r_ff, pix_g_ff, pix_b_ff);
         mfound_in    = found_ff;
         mindex_in    = INDEX_W'(idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tol_ff       <= TOL_RESET;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_r_ff     <= pix_r_in;
      pix_g_ff     <= pix_g_in;
      pix_b_ff     <= pix_b_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      idx_ff       <= idx_in;
      tone_ff      <= tone_in;
      mfound_ff    <= mfound_in;
      mindex_ff    <= mindex_in;
   end

   assign status.empty     = (count_ff == '0);
   assign status.hit       = hit;
   assign status.exhausted = !cmp_valid_ff && (scan_addr_ff >= count_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tone        = tone_ff;
   assign rsp_match_found = mfound_ff;
   assign rsp_match_index = mindex_ff;

endmodule

[src/pixel_tone_and_palette_match.sv]
// Top level of the pixel tone classifier with palette lookup.
//
//   channel    direction  beat content
//   req_port   in         operation, red, green, blue
//   rsp_port   out        tone, match_found, match_index (queries only)
//   csr_*      in         match_tolerance write, no read-back
//
// An append, clear or dropped beat is taken in the idle state, which the sequencer keeps.
// A query is scanned one registered palette read per cycle, compared in the cycle after
// its read, up to the first hit or the last stored entry; the result then goes to the output
// register, and no further request beat is taken until the result has been loaded there.
// Reset empties the palette and sets the tolerance to 20; palette entries keep
// whatever they held. A finished result waits in the output register; new beats
// are taken meanwhile, but a later query holds in its last step until that slot frees.
`include "pixel_tone_and_palette_match_assert.svh"

module pixel_tone_and_palette_match #(
   parameter int unsigned PALETTE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   ptpm_req_if.sink                    req_port,
   ptpm_rsp_if.source                  rsp_port,
   input  logic                        csr_write_enable,
   input  logic [ptpm_pkg::CHAN_W-1:0] csr_write_data
);
   import ptpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: takes request beats, walks the scan, hands off the result
   ptpm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_operation (req_port.operation),
      .req_ready     (req_port.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: palette memory, tolerance compare, tone rules, output register
   ptpm_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_red          (req_port.red),
      .req_green        (req_port.green),
      .req_blue         (req_port.blue),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_port.ready),
      .rsp_valid        (rsp_port.valid),
      .rsp_tone         (rsp_port.tone),
      .rsp_match_found  (rsp_port.match_found),
      .rsp_match_index  (rsp_port.match_index)
   );

   // a result is only loaded into a free output slot
   `PTPM_ASSERT_SAME(a_deliver_into_free_slot, cmd.deliver, status.rsp_free)
   // a started query blocks further request beats until it is delivered
   `PTPM_ASSERT_NEXT(a_scan_blocks_requests, cmd.start, !req_port.ready)
   // the sequencer issues at most one item-level command per cycle
   `PTPM_ASSERT_SAME(a_single_command, 1'b1,
      $onehot0({cmd.start, cmd.append, cmd.clear, cmd.deliver}))

endmodule
